FILE: rtl/core/sacp_pkg.sv
// Shared types and constants for the servo angle command parser.
`timescale 1ns / 1ps

package sacp_pkg;

  // Character codes the parser reacts to
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned MAG_W = 10;
  localparam int unsigned CNT_W = 12;
  localparam int unsigned ANG_W = 7;

  localparam logic [MAG_W-1:0] MAG_SAT   = 10'd1023;
  localparam logic [MAG_W-1:0] ANGLE_MAX = 10'd90;
  localparam logic [CNT_W-1:0] CNT_FIELD_MAX = 12'd4095;

  // Duty word math: ((a+90)*12+400)/20 == (3*(a+90)+100)/5
  localparam logic [7:0]  ANGLE_OFFSET = 8'd90;
  localparam logic [9:0]  DUTY_BIAS    = 10'd100;
  localparam logic [7:0]  DIV5_RECIP   = 8'd205;   // x/5 == (x*205)>>10 for x < 1024
  localparam int unsigned DIV5_SHIFT   = 10;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  // One finished command, handed from front to back
  typedef struct packed {
    logic [ANG_W-1:0] mag;   // magnitude already clamped to 0..90
    logic             neg;
    logic             err;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

endpackage

FILE: rtl/core/servo_angle_command_parser.sv
// Top level of the servo angle command parser.
`timescale 1ns / 1ps

// Servo angle command parser. Feed the ASCII bytes of a command on the slave
// stream, one byte per transaction, with tlast marking the final byte of a
// write. Digits build a decimal magnitude (saturating at 1023), a '-' as the
// first byte of a command makes it negative, a later '-' is ignored, and any
// other byte except newline sets the error flag. A newline or a tlast byte
// ends the command and produces one result transaction on the master stream:
// the angle clamped to -90..90, the PWM duty word ((angle+90)*12+400)/20 for a
// range of 1024, the byte count (terminator included, saturating at the
// smaller of COUNT_MAX and 4095) and the error flag on tuser. The block takes
// one byte per cycle while the queue has room, and the front end updates its
// accumulator as each byte is taken. Finished commands wait in a four-entry
// queue; each result passes from the queue to the back end's result register
// and appears on the master side from there. The slave side stalls only when
// that queue is full, which happens only while the master side is held off.

module servo_angle_command_parser #(
  parameter int unsigned COUNT_MAX = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] angle, [15:8] duty_word,
                                      // [27:16] bytes_used, [31:28] zero
  output logic        m_axis_tuser    // [0] bad_char
);

  logic                       queue_full, queue_push, queue_pop, queue_valid;
  sacp_pkg::cmd_t             push_cmd, head_cmd;
  logic [7:0]                 angle, duty_word;
  logic                       bad_char;
  logic [sacp_pkg::CNT_W-1:0] bytes_used;

  // Classify and accumulate incoming bytes
  sacp_front #(
    .COUNT_MAX(COUNT_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(s_axis_tvalid),
    .char_in_i   (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .queue_full_i(queue_full),
    .byte_ready_o(s_axis_tready),
    .push_o      (queue_push),
    .cmd_o       (push_cmd)
  );

  // Decouple front and back so each can stall on its own
  sacp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (queue_push),
    .push_cmd_i(push_cmd),
    .pop_i     (queue_pop),
    .full_o    (queue_full),
    .valid_o   (queue_valid),
    .head_o    (head_cmd)
  );

  // Compute angle and duty word, hold the result until taken
  sacp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (head_cmd),
    .pop_o       (queue_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .angle_o     (angle),
    .duty_word_o (duty_word),
    .bad_char_o  (bad_char),
    .bytes_used_o(bytes_used)
  );

  assign m_axis_tdata = {4'd0, bytes_used, duty_word, angle};
  assign m_axis_tuser = bad_char;

endmodule

FILE: rtl/core/sacp_front.sv
// Front end: accumulates the bytes of a command and posts the finished command.
`timescale 1ns / 1ps

module sacp_front #(
  parameter int unsigned COUNT_MAX = 4095
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          char_in_i,
  input  logic                last_byte_i,
  input  logic                queue_full_i,
  output logic                byte_ready_o,
  output logic                push_o,
  output sacp_pkg::cmd_t      cmd_o
);

  localparam logic [sacp_pkg::CNT_W-1:0] CntLimit =
    (COUNT_MAX < 4095) ? sacp_pkg::CNT_W'(COUNT_MAX) : sacp_pkg::CNT_FIELD_MAX;

  logic [sacp_pkg::MAG_W-1:0] mag_q, mag_d, mag_upd;
  logic                       neg_q, neg_d, neg_upd;
  logic                       err_q, err_d, err_upd;
  logic [sacp_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_upd;
  logic [13:0]                prod;
  logic                       is_digit, is_nl, is_minus, term, accept;

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  assign is_digit = (char_in_i >= sacp_pkg::CHAR_ZERO) && (char_in_i <= sacp_pkg::CHAR_NINE);
  assign is_nl    = (char_in_i == sacp_pkg::CHAR_NL);
  assign is_minus = (char_in_i == sacp_pkg::CHAR_MINUS);
  assign term     = is_nl || last_byte_i;

  // mag*10 + digit, saturate at the accumulator limit
  assign prod = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
              + {10'd0, char_in_i[3:0]};

  always_comb begin
    mag_upd = mag_q;
    neg_upd = neg_q;
    err_upd = err_q;
    if (is_digit) begin
      mag_upd = (prod > {4'd0, sacp_pkg::MAG_SAT}) ? sacp_pkg::MAG_SAT : prod[9:0];
    end else if (is_minus) begin
      if (cnt_q == '0) begin
        neg_upd = 1'b1;
      end
    end else if (!is_nl) begin
      err_upd = 1'b1;
    end
    cnt_upd = (cnt_q < CntLimit) ? cnt_q + 1'b1 : cnt_q;
  end

  always_comb begin
    mag_d = mag_q;
    neg_d = neg_q;
    err_d = err_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (term) begin
        mag_d = '0;
        neg_d = 1'b0;
        err_d = 1'b0;
        cnt_d = '0;
      end else begin
        mag_d = mag_upd;
        neg_d = neg_upd;
        err_d = err_upd;
        cnt_d = cnt_upd;
      end
    end
  end

  assign push_o    = accept && term;
  assign cmd_o.mag = (mag_upd > sacp_pkg::ANGLE_MAX) ? sacp_pkg::ANGLE_MAX[6:0]
                                                     : mag_upd[6:0];
  assign cmd_o.neg = neg_upd;
  assign cmd_o.err = err_upd;
  assign cmd_o.cnt = cnt_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= '0;
      neg_q <= 1'b0;
      err_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      err_q <= err_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/sacp_queue.sv
// Short queue of finished commands between front and back.
`timescale 1ns / 1ps

module sacp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sacp_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output sacp_pkg::cmd_t head_o
);

  sacp_pkg::cmd_t mem [sacp_pkg::QUEUE_DEPTH];

  logic [sacp_pkg::QUEUE_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [sacp_pkg::QUEUE_AW:0]   fill_q, fill_d;
  logic                          do_push, do_pop;

  assign full_o  = (fill_q == (sacp_pkg::QUEUE_AW+1)'(sacp_pkg::QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign head_o  = mem[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d   = do_push ? wr_q + 1'b1 : wr_q;
    rd_d   = do_pop  ? rd_q + 1'b1 : rd_q;
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

endmodule

FILE: rtl/core/sacp_back.sv
// Back end: turns a finished command into angle and duty word, holds the result.
`timescale 1ns / 1ps

module sacp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  sacp_pkg::cmd_t             cmd_i,
  output logic                       pop_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [7:0]                 angle_o,
  output logic [7:0]                 duty_word_o,
  output logic                       bad_char_o,
  output logic [sacp_pkg::CNT_W-1:0] bytes_used_o
);

  logic                       valid_q, valid_d;
  logic [7:0]                 angle_q, angle_d;
  logic [7:0]                 duty_q, duty_d;
  logic                       bad_q;
  logic [sacp_pkg::CNT_W-1:0] cnt_q;
  logic [7:0]                 shifted;
  logic [9:0]                 scaled;
  logic [17:0]                recip_prod;

  assign pop_o = cmd_valid_i && (!valid_q || res_ready_i);

  always_comb begin
    angle_d = cmd_i.neg ? 8'(-{1'b0, cmd_i.mag}) : {1'b0, cmd_i.mag};
    shifted = cmd_i.neg ? sacp_pkg::ANGLE_OFFSET - {1'b0, cmd_i.mag}
                        : sacp_pkg::ANGLE_OFFSET + {1'b0, cmd_i.mag};
    // 3x + 100, then divide by five through the reciprocal
    scaled     = {1'b0, shifted, 1'b0} + {2'b00, shifted} + sacp_pkg::DUTY_BIAS;
    recip_prod = scaled * sacp_pkg::DIV5_RECIP;
    duty_d     = recip_prod[sacp_pkg::DIV5_SHIFT +: 8];
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (res_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      angle_q <= angle_d;
      duty_q  <= duty_d;
      bad_q   <= cmd_i.err;
      cnt_q   <= cmd_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign res_valid_o  = valid_q;
  assign angle_o      = angle_q;
  assign duty_word_o  = duty_q;
  assign bad_char_o   = bad_q;
  assign bytes_used_o = cnt_q;

endmodule
